// ===== rtl/tsnf_pkg.sv =====
// shared types and constants for the transport stream null packet filter framer
package tsnf_pkg;

  localparam logic [7:0]  SYNC_BYTE       = 8'h47;
  localparam logic [12:0] NULL_PID        = 13'h1fff;
  localparam logic [4:0]  PID_HI_MASK     = 5'h1f;
  localparam int          PPF_W           = 7;
  localparam logic [6:0]  PPF_RESET       = 7'd7;

  // one queued emit job: a single word, or two held header bytes plus the pid byte
  typedef struct packed {
    logic [7:0] hdr0;
    logic [7:0] hdr1;
    logic [7:0] data;
    logic       fe;
    logic       triple;
  } tsnf_entry_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR1 = 3'b010,
    ST_DATA = 3'b100
  } tsnf_back_state_t;

endpackage

// ===== rtl/tsnf_front.sv =====
// front end: sync hunt, packet position, pid classification and frame counting
module tsnf_front
  import tsnf_pkg::*;
#(
  parameter int PACKET_LEN = 188
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [PPF_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  q_full,
  output logic                  push,
  output tsnf_entry_t           push_entry
);

  localparam int PosW = $clog2(PACKET_LEN);

  logic [PPF_W-1:0] packets_per_frame;
  logic             hunting;
  logic [PosW-1:0]  byte_position;
  logic [7:0]       hdr0;
  logic [7:0]       hdr1;
  logic             keep_packet;
  logic [PPF_W-1:0] kept_in_frame;

  logic             accept;
  logic             pkt_end;
  logic             pid_pos;
  logic             keep_now;
  logic [PPF_W-1:0] target;
  logic [PPF_W:0]   cnt;
  logic             frame_done;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign pkt_end    = byte_position >= PosW'(PACKET_LEN - 1);
  assign pid_pos    = byte_position == PosW'(2);
  assign keep_now   = pid_pos ? ({hdr1[4:0] & PID_HI_MASK, in_byte} != NULL_PID) : keep_packet;
  assign target     = (packets_per_frame == '0) ? PPF_W'(1) : packets_per_frame;
  assign cnt        = {1'b0, kept_in_frame} + (PPF_W + 1)'(1);
  assign frame_done = keep_now && pkt_end && (cnt >= {1'b0, target});

  // a word goes to the queue for every byte from the pid byte on of a kept packet
  assign push = accept && !hunting && (byte_position >= PosW'(2)) && keep_now;

  always_comb begin
    push_entry.hdr0   = hdr0;
    push_entry.hdr1   = hdr1;
    push_entry.data   = in_byte;
    push_entry.fe     = frame_done;
    push_entry.triple = pid_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packets_per_frame <= PPF_RESET;
    end else if (cfg_we) begin
      packets_per_frame <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting       <= 1'b1;
      byte_position <= '0;
      keep_packet   <= 1'b0;
      kept_in_frame <= '0;
    end else if (accept) begin
      if (hunting) begin
        if (in_byte == SYNC_BYTE) begin
          hunting       <= 1'b0;
          byte_position <= PosW'(1);
        end
      end else begin
        if (pid_pos) begin
          keep_packet <= keep_now;
        end
        if (keep_now && pkt_end && (byte_position >= PosW'(2))) begin
          if (frame_done) begin
            kept_in_frame <= '0;
            hunting       <= 1'b1;
          end else begin
            kept_in_frame <= cnt[PPF_W-1:0];
          end
        end
        byte_position <= pkt_end ? '0 : byte_position + PosW'(1);
      end
    end
  end

  // header bytes, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (hunting) begin
        if (in_byte == SYNC_BYTE) begin
          hdr0 <= in_byte;
        end
      end else if (byte_position == '0) begin
        hdr0 <= in_byte;
      end else if (byte_position == PosW'(1)) begin
        hdr1 <= in_byte;
      end
    end
  end

endmodule

// ===== rtl/tsnf_queue.sv =====
// small register fifo of emit jobs between front and back end
module tsnf_queue
  import tsnf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tsnf_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output tsnf_entry_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsnf_entry_t    mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/tsnf_back.sv =====
// back end: expands queued jobs into output words behind an output register
module tsnf_back
  import tsnf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  tsnf_entry_t q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        run_last
);

  tsnf_back_state_t state;
  tsnf_entry_t      cur;
  logic             load;

  assign load = !out_valid || out_ready;
  assign pop  = load && (state == ST_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else if (load) begin
      unique case (state)
        ST_IDLE: begin
          out_valid <= q_not_empty;
          if (q_not_empty && q_head.triple) begin
            state <= ST_HDR1;
          end
        end
        ST_HDR1: begin
          out_valid <= 1'b1;
          state     <= ST_DATA;
        end
        ST_DATA: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      unique case (state)
        ST_IDLE: begin
          cur <= q_head;
          if (q_head.triple) begin
            out_byte  <= q_head.hdr0;
            frame_end <= 1'b0;
            run_last  <= 1'b0;
          end else begin
            out_byte  <= q_head.data;
            frame_end <= q_head.fe;
            run_last  <= 1'b1;
          end
        end
        ST_HDR1: begin
          out_byte  <= cur.hdr1;
          frame_end <= 1'b0;
          run_last  <= 1'b0;
        end
        ST_DATA: begin
          out_byte  <= cur.data;
          frame_end <= cur.fe;
          run_last  <= 1'b1;
        end
        default: begin
          out_byte  <= cur.data;
          frame_end <= 1'b0;
          run_last  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ts_null_packet_filter_framer.sv =====
// top level of the transport stream null packet filter framer
// path: each kept byte from the pid byte on is pushed into the job queue, and the back end
// expands each job into the registered output; the pid byte job also emits both header bytes
// throughput: one input word per cycle unless the queue is full; a kept pid byte costs three words
// the job queue absorbs that burst, the rest goes one word per cycle on both sides unless stalled
// reset: synchronous, returns to sync hunt, empties the queue, packets_per_frame back to 7
module ts_null_packet_filter_framer
  import tsnf_pkg::*;
#(
  parameter int PACKET_LEN  = 188,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  // configuration: packets_per_frame
  input  logic             cfg_we,
  input  logic [PPF_W-1:0] cfg_wdata,
  // input byte stream
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  // output word stream
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             frame_end,
  output logic             run_last
);

  // front to queue
  logic        push;
  tsnf_entry_t push_entry;
  logic        q_full;

  // queue to back
  logic        pop;
  logic        q_not_empty;
  tsnf_entry_t q_head;

  // front end classifies each byte: hunt, hold header, drop or emit
  tsnf_front #(
    .PACKET_LEN (PACKET_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the one-word-per-byte front from the three-word header burst
  tsnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back end sequences words into the registered output
  tsnf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .run_last    (run_last)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the transport stream null packet filter framer
module testbench
  import tsnf_pkg::*;
();

  localparam int PKT_LEN    = 188;      // bytes per transport packet
  localparam int SETTLE     = 12;       // quiet cycles once nothing is outstanding
  localparam int CYCLE_CAP  = 20000;    // far above the slowest legal run
  localparam int IDLE_PCT   = 22;

  // one expected output word
  typedef struct {
    logic [7:0] data;
    logic       fe;
    logic       last;
  } kept_word_t;

  // tracks sync, packet position and frame count, and holds the words the
  // block owes us in arrival order
  class kept_word_board;
    kept_word_t       kept_words[$];
    int               errors;
    logic [6:0]       frame_len;
    logic             in_hunt;
    logic [7:0]       pkt_pos;
    logic [7:0]       hdr_hold[2];
    logic             pass_pkt;
    logic [6:0]       kept_count;

    function new();
      errors     = 0;
      frame_len  = PPF_RESET;
      in_hunt    = 1'b1;
      pkt_pos    = '0;
      hdr_hold   = '{8'h00, 8'h00};
      pass_pkt   = 1'b0;
      kept_count = '0;
    endfunction

    function void push_word(logic [7:0] d, logic fe, logic last);
      kept_word_t w;
      w.data = d;
      w.fe   = fe;
      w.last = last;
      kept_words.push_back(w);
    endfunction

    // one accepted input byte
    function void take_byte(logic [7:0] b);
      logic        pkt_end;
      logic        fe;
      logic [12:0] pid;
      int          target;
      fe = 1'b0;
      if (in_hunt) begin
        // everything before the sync byte is thrown away
        if (b == SYNC_BYTE) begin
          in_hunt     = 1'b0;
          hdr_hold[0] = b;
          pkt_pos     = 8'd1;
        end
        return;
      end
      pkt_end = (int'(pkt_pos) >= PKT_LEN - 1);
      if (pkt_pos == 8'd0) begin
        hdr_hold[0] = b;
      end else if (pkt_pos == 8'd1) begin
        hdr_hold[1] = b;
      end else begin
        if (pkt_pos == 8'd2) begin
          pid      = {hdr_hold[1][4:0] & PID_HI_MASK, b};
          pass_pkt = (pid != NULL_PID);
        end
        if (pass_pkt && pkt_end) begin
          // zero frame length behaves as one
          target = (frame_len == '0) ? 1 : int'(frame_len);
          if (int'(kept_count) + 1 >= target) begin
            fe         = 1'b1;
            kept_count = '0;
            in_hunt    = 1'b1;
          end else begin
            kept_count = kept_count + 7'd1;
          end
        end
        if (pass_pkt) begin
          if (pkt_pos == 8'd2) begin
            push_word(hdr_hold[0], 1'b0, 1'b0);
            push_word(hdr_hold[1], 1'b0, 1'b0);
          end
          push_word(b, fe, 1'b1);
        end
      end
      pkt_pos = pkt_end ? 8'd0 : pkt_pos + 8'd1;
    endfunction

    // one accepted output word against the oldest expectation
    function void match_word(logic [7:0] d, logic fe, logic last);
      kept_word_t w;
      if (kept_words.size() == 0) begin
        $error("unexpected word: out_byte %0h frame_end %0b run_last %0b", d, fe, last);
        errors++;
        return;
      end
      w = kept_words.pop_front();
      if (d !== w.data) begin
        $error("out_byte: expected %0h, got %0h", w.data, d);
        errors++;
      end
      if (fe !== w.fe) begin
        $error("frame_end: expected %0b, got %0b", w.fe, fe);
        errors++;
      end
      if (last !== w.last) begin
        $error("run_last: expected %0b, got %0b", w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return kept_words.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [PPF_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic             frame_end;
  logic             run_last;

  kept_word_board tracker;
  logic           calm;       // set to switch off idling on both sides
  int             cycles = 0;

  ts_null_packet_filter_framer #(
    .PACKET_LEN (PKT_LEN)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

  always #5 clk = ~clk;

  // output side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // every accepted output word is checked on the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.match_word(out_byte, frame_end, run_last);
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // offer one byte, with random idle cycles ahead of it, and wait for the handshake
  task automatic put_byte(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    tracker.take_byte(b);
  endtask

  // any byte except the sync byte, for the hunt before a frame
  task automatic put_junk(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom); while (b == SYNC_BYTE);
      put_byte(b);
    end
  endtask

  // the first len bytes of a packet; a sync hunt is satisfied first when the block
  // is hunting, otherwise the first byte is mostly sync but not always (it is not checked)
  task automatic put_packet(input logic [12:0] pid, input int len);
    logic [7:0] b0;
    if (tracker.in_hunt) begin
      put_junk($urandom_range(0, 5));
      b0 = SYNC_BYTE;
    end else begin
      b0 = ($urandom_range(3) == 0) ? 8'($urandom) : SYNC_BYTE;
    end
    put_byte(b0);
    put_byte({3'($urandom), pid[12:8]});
    put_byte(pid[7:0]);
    for (int i = 3; i < len; i++) begin
      // stray sync bytes inside the packet must pass through untouched
      put_byte(($urandom_range(15) == 0) ? SYNC_BYTE : 8'($urandom));
    end
  endtask

  // stop offering input and wait until every owed word is out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write while the block is quiet
  task automatic set_frame_len(input logic [PPF_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tracker.frame_len = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    tracker   = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_byte   = '0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset frame length of seven; hunt over field extremes and near-sync values
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h46);
    // kept packet next to the null pid: first of seven, no frame end
    put_packet(13'h1ffe, PKT_LEN);

    // zero acts as one: the carried count closes the frame at once; no idling here
    set_frame_len(7'd0);
    calm = 1'b1;
    put_packet(13'h0000, PKT_LEN);
    drain();
    calm = 1'b0;

    // back in the hunt: the head of a null packet is swallowed whole
    put_packet(NULL_PID, 10);

    drain();
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
